>>> rtl/fsk_pkg.sv
// shared types, constants and sine table of the fsk tone modulator
`timescale 1ns / 1ps

package fsk_pkg;

	localparam int NUM_SYMBOLS     = 79;
	localparam int SINE_TABLE_BITS = 10;

	// symbol index width and divider step counter width
	localparam int SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int DIV_CNT_W = (SYM_W > 1) ? $clog2(SYM_W) : 1;

	localparam int SPS_W   = 14;
	localparam int COUNT_W = 24;
	localparam int PHASE_W = 32;
	localparam int AMP_W   = 16;
	localparam int MAG_W   = 15;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// width of the run length, symbols times samples per symbol
	localparam int RUN_W   = SPS_W + SYM_W + 1;

	localparam int QTR_W   = SINE_TABLE_BITS - 2;
	localparam int QUARTER = 1 << QTR_W;

	localparam logic [AMP_W-1:0] FULL_AMP  = 16'd32767;
	localparam logic [MAG_W-1:0] DECAY_Q15 = 15'd32113;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SAMPLES_PER_SYMBOL = 3'd0;
	localparam logic [2:0] REG_BASE_PHASE_STEP    = 3'd1;
	localparam logic [2:0] REG_TONE_PHASE_STEP    = 3'd2;
	localparam logic [2:0] REG_TUNING_MODE        = 3'd3;
	localparam logic [2:0] REG_START_WAIT_SAMPLES = 3'd4;
	localparam logic [2:0] REG_FADE_START_SAMPLE  = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SYNC   = 2'd1,
		MODE_ACTIVE = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_STEP,
		ST_PHASE,
		ST_LUT,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [SPS_W-1:0]   samples_per_symbol;
		logic [PHASE_W-1:0] base_phase_step;
		logic [PHASE_W-1:0] tone_phase_step;
		logic               tuning_mode;
		logic [COUNT_W-1:0] start_wait_samples;
		logic [COUNT_W-1:0] fade_start_sample;
	} cfg_t;

	typedef struct packed {
		logic                 accept;
		logic                 div_step;
		logic [DIV_CNT_W-1:0] div_bit;
		logic                 tone_rd;
		logic                 step;
		logic                 phase;
		logic                 lut;
		logic                 mul;
		logic                 fin;
		logic                 load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic tick_work;
		logic tuning;
	} dp_status_t;

	typedef logic [MAG_W-1:0] sine_lut_t [QUARTER];

	// quarter-wave sine magnitude in q15, odd series to x^9 in q30
	function automatic logic [MAG_W-1:0] sine_mag(input int unsigned m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		x  = (64'(m) * HALF_PI_Q30) >> QTR_W;
		x2 = (x * x) >> 30;
		t  = ONE_Q30 - x2 / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		r  = (s + 64'd16384) >> 15;
		return (r > 64'd32767) ? 15'd32767 : r[MAG_W-1:0];
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		for (int i = 0; i < QUARTER; i++) begin
			lut[i] = sine_mag(i);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();
	// entry at the quarter-wave peak, outside the table
	localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

>>> rtl/fsk_regs.sv
// apb configuration registers of the fsk tone modulator
`timescale 1ns / 1ps

module fsk_regs import fsk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_symbol <= 14'd1920;
			cfg_q.base_phase_step    <= '0;
			cfg_q.tone_phase_step    <= '0;
			cfg_q.tuning_mode        <= 1'b0;
			cfg_q.start_wait_samples <= '0;
			cfg_q.fade_start_sample  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SAMPLES_PER_SYMBOL: cfg_q.samples_per_symbol <= pwdata[SPS_W-1:0];
				REG_BASE_PHASE_STEP:    cfg_q.base_phase_step    <= pwdata[PHASE_W-1:0];
				REG_TONE_PHASE_STEP:    cfg_q.tone_phase_step    <= pwdata[PHASE_W-1:0];
				REG_TUNING_MODE:        cfg_q.tuning_mode        <= pwdata[0];
				REG_START_WAIT_SAMPLES: cfg_q.start_wait_samples <= pwdata[COUNT_W-1:0];
				REG_FADE_START_SAMPLE:  cfg_q.fade_start_sample  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SAMPLES_PER_SYMBOL: prdata = DATA_W'(cfg_q.samples_per_symbol);
			REG_BASE_PHASE_STEP:    prdata = DATA_W'(cfg_q.base_phase_step);
			REG_TONE_PHASE_STEP:    prdata = DATA_W'(cfg_q.tone_phase_step);
			REG_TUNING_MODE:        prdata = DATA_W'(cfg_q.tuning_mode);
			REG_START_WAIT_SAMPLES: prdata = DATA_W'(cfg_q.start_wait_samples);
			REG_FADE_START_SAMPLE:  prdata = DATA_W'(cfg_q.fade_start_sample);
			default:                prdata = '0;
		endcase
	end

endmodule

>>> rtl/fsk_ctrl.sv
// sequencer state machine of the fsk tone modulator
`timescale 1ns / 1ps

module fsk_ctrl import fsk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t          state_q;
	ctrl_state_t          state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				div_cnt_q <= DIV_CNT_W'(SYM_W - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					if (status.tick_work) begin
						state_d = status.tuning ? ST_RD : ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_bit  = div_cnt_q;
				if (div_cnt_q == '0) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.tone_rd = 1'b1;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.phase = 1'b1;
				state_d   = ST_LUT;
			end
			ST_LUT: begin
				cmd.lut = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/fsk_datapath.sv
// run state, symbol divider, tone store and sine datapath
`timescale 1ns / 1ps

module fsk_datapath import fsk_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	input  logic [1:0]          op,
	input  logic [6:0]          tone_index,
	input  logic [2:0]          tone_value,
	output logic signed [15:0]  sample,
	output logic [1:0]          run_state,
	output logic [COUNT_W-1:0]  wait_left
);

	mode_t              mode_q;
	logic [COUNT_W-1:0] silence_q;
	logic [COUNT_W-1:0] sample_count_q;
	logic [PHASE_W-1:0] phase_acc_q;
	logic [PHASE_W-1:0] phase_step_q;
	logic [AMP_W-1:0]   amplitude_q;

	logic [2:0]         tone_mem [NUM_SYMBOLS];
	logic [2:0]         tone_rd_q;

	logic [COUNT_W-1:0] rem_q;
	logic [SYM_W-1:0]   quo_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [30:0]        prod_q;
	logic [15:0]        sample_q;

	logic [15:0]        out_sample_q;
	logic [1:0]         out_mode_q;
	logic [COUNT_W-1:0] out_wait_q;

	op_t                op_c;
	logic [RUN_W-1:0]   run_len;
	logic               past_end;
	logic               silence_zero;
	logic [COUNT_W-1:0] div_trial;
	logic [SYM_W-1:0]   rd_addr;
	logic               load_hit;
	logic [34:0]        tone_prod;
	logic [30:0]        decay_prod;
	logic [SINE_TABLE_BITS-1:0] k;
	logic [1:0]         quad;
	logic [QTR_W:0]     m;
	logic [MAG_W-1:0]   mag_c;
	logic [30:0]        amp_prod;
	logic [31:0]        rounded;
	logic [15:0]        mag16;

	assign op_c         = op_t'(op);
	assign run_len      = RUN_W'(NUM_SYMBOLS) * RUN_W'(cfg.samples_per_symbol);
	assign past_end     = sample_count_q >= COUNT_W'(run_len);
	assign silence_zero = (silence_q == '0);

	// ticks of an active or just-active run go on if tuning or not past end
	assign status.tick_work = (op_c == OP_TICK)
		&& ((mode_q == MODE_ACTIVE) || ((mode_q == MODE_SYNC) && silence_zero))
		&& (cfg.tuning_mode || !past_end);
	assign status.tuning = cfg.tuning_mode;

	assign div_trial  = COUNT_W'(cfg.samples_per_symbol) << cmd.div_bit;
	assign rd_addr    = cfg.tuning_mode ? '0 : quo_q;
	assign load_hit   = cmd.accept && (op_c == OP_LOAD)
		&& (8'(tone_index) < 8'(NUM_SYMBOLS));
	assign tone_prod  = 35'(tone_rd_q) * 35'(cfg.tone_phase_step);
	assign decay_prod = 31'(amplitude_q) * 31'(DECAY_Q15);

	// quarter-wave folding of the top phase bits
	assign k     = phase_acc_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign quad  = k[SINE_TABLE_BITS-1 -: 2];
	assign m     = quad[0] ? ((QTR_W+1)'(QUARTER) - {1'b0, k[QTR_W-1:0]})
		: {1'b0, k[QTR_W-1:0]};
	assign mag_c = m[QTR_W] ? SINE_PEAK : SINE_LUT[m[QTR_W-1:0]];

	assign amp_prod = 31'(amplitude_q) * 31'(mag_q);
	assign rounded  = 32'(prod_q) + 32'd16384;
	assign mag16    = rounded[30:15];

	assign sample    = $signed(out_sample_q);
	assign run_state = out_mode_q;
	assign wait_left = out_wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			silence_q      <= '0;
			sample_count_q <= '0;
			phase_acc_q    <= '0;
			phase_step_q   <= '0;
			amplitude_q    <= FULL_AMP;
		end else if (cmd.accept) begin
			unique case (op_c)
				OP_TICK: begin
					if ((mode_q == MODE_SYNC) && !silence_zero) begin
						silence_q <= silence_q - 1'b1;
						if (silence_q == COUNT_W'(1)) begin
							mode_q <= MODE_ACTIVE;
						end
					end else if (mode_q != MODE_IDLE) begin
						if (!cfg.tuning_mode && past_end) begin
							mode_q      <= MODE_IDLE;
							phase_acc_q <= '0;
						end else begin
							mode_q <= MODE_ACTIVE;
						end
					end
				end
				OP_START: begin
					if (cfg.samples_per_symbol == '0) begin
						mode_q         <= MODE_IDLE;
						silence_q      <= '0;
						sample_count_q <= '0;
						phase_acc_q    <= '0;
					end else begin
						phase_acc_q    <= '0;
						phase_step_q   <= '0;
						amplitude_q    <= FULL_AMP;
						sample_count_q <= '0;
						silence_q      <= cfg.tuning_mode ? '0 : cfg.start_wait_samples;
						mode_q         <= (!cfg.tuning_mode && (cfg.start_wait_samples != '0))
							? MODE_SYNC : MODE_ACTIVE;
					end
				end
				OP_STOP: begin
					mode_q         <= MODE_IDLE;
					silence_q      <= '0;
					sample_count_q <= '0;
					phase_acc_q    <= '0;
				end
				OP_LOAD: ;
			endcase
		end else if (cmd.step) begin
			phase_step_q <= cfg.base_phase_step + tone_prod[PHASE_W-1:0];
			if (!cfg.tuning_mode && (sample_count_q > cfg.fade_start_sample)) begin
				amplitude_q <= decay_prod[30:15];
			end
		end else if (cmd.phase) begin
			phase_acc_q <= phase_acc_q + phase_step_q;
		end else if (cmd.fin) begin
			sample_count_q <= sample_count_q + 1'b1;
			if (amplitude_q == '0) begin
				mode_q      <= MODE_IDLE;
				phase_acc_q <= '0;
			end
		end
	end

	// tone store, one write and one registered read
	always_ff @(posedge clk) begin
		if (load_hit) begin
			tone_mem[tone_index[SYM_W-1:0]] <= tone_value;
		end
		if (cmd.tone_rd) begin
			tone_rd_q <= tone_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rem_q    <= sample_count_q;
			quo_q    <= '0;
			sample_q <= '0;
		end
		// restoring division, one quotient bit per step
		if (cmd.div_step && (rem_q >= div_trial)) begin
			rem_q             <= rem_q - div_trial;
			quo_q[cmd.div_bit] <= 1'b1;
		end
		if (cmd.lut) begin
			mag_q <= mag_c;
			neg_q <= quad[1];
		end
		if (cmd.mul) begin
			prod_q <= amp_prod;
		end
		if (cmd.fin) begin
			sample_q <= neg_q ? (16'd0 - mag16) : mag16;
		end
		if (cmd.load_out) begin
			out_sample_q <= sample_q;
			out_mode_q   <= mode_q;
			out_wait_q   <= silence_q;
		end
	end

endmodule

>>> rtl/fsk_tone_modulator.sv
// top level of the continuous-phase 8-tone fsk audio modulator
// usage:
//  - input channel (in_valid/in_ready) carries one command per transaction:
//    tick one sample, start a run, stop, or load the tone of one symbol
//  - output channel (out_valid/out_ready) returns one result per command:
//    signed q1.15 sample, run state and silent samples left
//  - configuration goes through the apb port, register i at byte 4*i, and
//    is written by the user only while no command is in flight (unenforced)
//  - start, stop, load and silent ticks go from accept straight to the done
//    state and the output register; tuning mode skips the divider
//  - a sounding tick runs the 7-step symbol divider (sample count
//    over samples per symbol), the tone store read and the sine path
//  - one command is in work at a time; in_ready is high only when the
//    sequencer is back in its idle state, so a new command is taken only
//    once the result of the last one is in the output register
//  - the output register lets the next command be accepted while a result
//    still waits; if the receiver stalls, the following result holds the
//    sequencer until the register is free, so nothing is lost
//  - reset clears the run state to idle, counters and phase to zero and
//    amplitude to full scale; the tone store is undefined until loaded
`timescale 1ns / 1ps

module fsk_tone_modulator import fsk_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [6:0]          tone_index,
	input  logic [2:0]          tone_value,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  sample,
	output logic [1:0]          run_state,
	output logic [COUNT_W-1:0]  wait_left,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// register file; the user keeps it static during a run between commands, unenforced
	fsk_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accepts a transaction, steps the datapath, hands off the result
	fsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// run state, phase accumulator, amplitude decay and sine lookup
	fsk_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.tone_index (tone_index),
		.tone_value (tone_value),
		.sample     (sample),
		.run_state  (run_state),
		.wait_left  (wait_left)
	);

endmodule
